### hdl/gsm_pkg.sv
// Shared constants and types for the 1-D Gaussian smoothing unit.
// No dependencies; used by every module in hdl/.
package gsm_pkg;

    localparam int MAX_HALF_WIDTH_DEF = 3;
    localparam int HEIGHT_BITS_DEF    = 16;

    localparam int WEIGHT_W    = 16;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_WEIGHTS = 4;
    localparam int HALF_W_W    = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_WIDTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_CENTER = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_OFF1   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_OFF2   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_OFF3   = 3'd4;

    localparam logic [HALF_W_W-1:0] HALF_WIDTH_RST    = 2'd2;
    localparam logic [WEIGHT_W-1:0] WEIGHT_CENTER_RST = 16'd26386;
    localparam logic [WEIGHT_W-1:0] WEIGHT_OFF1_RST   = 16'd16004;
    localparam logic [WEIGHT_W-1:0] WEIGHT_OFF2_RST   = 16'd3571;
    localparam logic [WEIGHT_W-1:0] WEIGHT_OFF3_RST   = 16'd0;

    // Status of the window stage: a result is due from the current window.
    typedef struct packed {
        logic valid;
        logic last;
    } gsm_tag_t;

endpackage

### hdl/gaussian_smoothing_1d_unit.sv
// 1-D Gaussian smoothing unit, top level: config registers, window, MAC pipeline.
// Depends on gsm_pkg, gsm_window, gsm_mac.
//
// Smooths a streamed row of signed heights with a symmetric kernel of 2*half_width+1
// unsigned Q0.16 taps; bins outside the row count as zero. One height beat per
// cycle is taken while s_tready is high. The result for bin i passes the window
// register, product register and output register after bin i+half_width enters.
// A beat with tlast flushes the p still-pending bins: it yields p+1 results and
// s_tready stays low while the window shifts zeros toward the center tap.
// The user must write registers only while the unit is idle; the unit itself
// does not enforce this.
module gaussian_smoothing_1d_unit #(
    parameter int MAX_HALF_WIDTH = gsm_pkg::MAX_HALF_WIDTH_DEF,
    parameter int HEIGHT_BITS    = gsm_pkg::HEIGHT_BITS_DEF,
    parameter int DATA_W         = ((HEIGHT_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [gsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gsm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [DATA_W-1:0]                  s_tdata,   // height
    input  logic                               s_tlast,   // row_end
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [DATA_W-1:0]                  m_tdata,   // smoothed
    output logic                               m_tlast    // last_out
);

    localparam int WIN_DEPTH = 2 * MAX_HALF_WIDTH + 1;
    localparam int HW_W      = $clog2(MAX_HALF_WIDTH + 1);

    logic [gsm_pkg::HALF_W_W-1:0] half_width_reg;
    logic [gsm_pkg::WEIGHT_W-1:0] weight_reg [gsm_pkg::NUM_WEIGHTS];
    logic [HW_W-1:0]              hw;
    gsm_pkg::gsm_tag_t            win_tag;
    logic signed [HEIGHT_BITS-1:0] win [WIN_DEPTH];
    logic                         mac_ready;
    logic [HEIGHT_BITS-1:0]       smoothed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg <= gsm_pkg::HALF_WIDTH_RST;
            weight_reg[0]  <= gsm_pkg::WEIGHT_CENTER_RST;
            weight_reg[1]  <= gsm_pkg::WEIGHT_OFF1_RST;
            weight_reg[2]  <= gsm_pkg::WEIGHT_OFF2_RST;
            weight_reg[3]  <= gsm_pkg::WEIGHT_OFF3_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gsm_pkg::CFG_HALF_WIDTH: begin
                    half_width_reg <= cfg_wdata[gsm_pkg::HALF_W_W-1:0];
                end
                gsm_pkg::CFG_WEIGHT_CENTER: weight_reg[0] <= cfg_wdata;
                gsm_pkg::CFG_WEIGHT_OFF1:   weight_reg[1] <= cfg_wdata;
                gsm_pkg::CFG_WEIGHT_OFF2:   weight_reg[2] <= cfg_wdata;
                gsm_pkg::CFG_WEIGHT_OFF3:   weight_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (int'(half_width_reg) > MAX_HALF_WIDTH) begin
            hw = HW_W'(MAX_HALF_WIDTH);
        end else begin
            hw = HW_W'(half_width_reg);
        end
    end

    gsm_window #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .HEIGHT_BITS    (HEIGHT_BITS),
        .WIN_DEPTH      (WIN_DEPTH),
        .HW_W           (HW_W)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hw        (hw),
        .in_valid  (s_tvalid),
        .in_height (s_tdata[HEIGHT_BITS-1:0]),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .advance   (mac_ready),
        .tag       (win_tag),
        .win       (win)
    );

    gsm_mac #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .HEIGHT_BITS    (HEIGHT_BITS),
        .WIN_DEPTH      (WIN_DEPTH),
        .HW_W           (HW_W)
    ) u_mac (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .hw           (hw),
        .weight       (weight_reg),
        .tag          (win_tag),
        .win          (win),
        .ready        (mac_ready),
        .out_valid    (m_tvalid),
        .out_smoothed (smoothed),
        .out_last     (m_tlast),
        .out_ready    (m_tready)
    );

    assign m_tdata = DATA_W'(smoothed);

    a_ready_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!win_tag.valid || mac_ready))
        else $error("input taken while window result is stalled");

    a_row_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> win_tag.valid)
        else $error("row end beat produced no pending result");

    a_last_is_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        win_tag.last |-> win_tag.valid)
        else $error("last marker without a result");

endmodule

### hdl/gsm_window.sv
// Sample window and row control: shift line, primed count, end-of-row flush.
// Depends on gsm_pkg.
module gsm_window #(
    parameter int MAX_HALF_WIDTH = gsm_pkg::MAX_HALF_WIDTH_DEF,
    parameter int HEIGHT_BITS    = gsm_pkg::HEIGHT_BITS_DEF,
    parameter int WIN_DEPTH      = 2 * MAX_HALF_WIDTH + 1,
    parameter int HW_W           = $clog2(MAX_HALF_WIDTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [HW_W-1:0]               hw,
    input  logic                          in_valid,
    input  logic signed [HEIGHT_BITS-1:0] in_height,
    input  logic                          in_last,
    output logic                          in_ready,
    input  logic                          advance,
    output gsm_pkg::gsm_tag_t             tag,
    output logic signed [HEIGHT_BITS-1:0] win [WIN_DEPTH]
);

    localparam int EXT_DEPTH = MAX_HALF_WIDTH + 1 + WIN_DEPTH;

    logic signed [HEIGHT_BITS-1:0] window_reg  [WIN_DEPTH];
    logic signed [HEIGHT_BITS-1:0] window_next [WIN_DEPTH];
    logic signed [HEIGHT_BITS-1:0] base        [WIN_DEPTH];
    logic signed [HEIGHT_BITS-1:0] ext         [EXT_DEPTH];
    logic signed [HEIGHT_BITS-1:0] shifted     [WIN_DEPTH];
    logic [HW_W-1:0]  primed_reg, primed_next;
    logic [HW_W-1:0]  flush_reg, flush_next;
    gsm_pkg::gsm_tag_t tag_reg, tag_next;
    logic [HW_W-1:0]  p_eff;
    logic [HW_W:0]    offset_wide;
    logic [HW_W-1:0]  offset;
    logic             consume;
    logic             accept;

    assign p_eff    = (primed_reg > hw) ? hw : primed_reg;
    assign consume  = tag_reg.valid && advance;
    assign in_ready = (flush_reg == '0) && (!tag_reg.valid || advance);
    assign accept   = in_valid && in_ready;

    // Row end: shift extra zeros so the oldest pending bin lands on the center tap.
    assign offset_wide = (HW_W + 1)'(MAX_HALF_WIDTH) - {1'b0, hw} + {1'b0, p_eff};
    assign offset      = in_last ? offset_wide[HW_W-1:0] : HW_W'(MAX_HALF_WIDTH);

    always_comb begin
        for (int k = 0; k < WIN_DEPTH; k++) begin
            base[k] = (tag_reg.valid && tag_reg.last) ? '0 : window_reg[k];
        end
        for (int i = 0; i < EXT_DEPTH; i++) begin
            ext[i] = '0;
        end
        ext[MAX_HALF_WIDTH] = in_height;
        for (int j = 0; j < WIN_DEPTH; j++) begin
            ext[MAX_HALF_WIDTH + 1 + j] = base[j];
        end
        for (int k = 0; k < WIN_DEPTH; k++) begin
            shifted[k] = '0;
            for (int j = 0; j <= MAX_HALF_WIDTH; j++) begin
                if (offset == HW_W'(j)) begin
                    shifted[k] = ext[j + k];
                end
            end
        end
    end

    always_comb begin
        window_next = window_reg;
        primed_next = primed_reg;
        flush_next  = flush_reg;
        tag_next    = tag_reg;
        if (accept) begin
            window_next   = shifted;
            tag_next.valid = in_last || (p_eff == hw);
            tag_next.last  = in_last && (p_eff == '0);
            flush_next    = in_last ? p_eff : '0;
            if (in_last) begin
                primed_next = '0;
            end else if (p_eff == hw) begin
                primed_next = p_eff;
            end else begin
                primed_next = p_eff + 1'b1;
            end
        end else if (consume) begin
            if (flush_reg != '0) begin
                window_next[0] = '0;
                for (int k = 1; k < WIN_DEPTH; k++) begin
                    window_next[k] = window_reg[k - 1];
                end
                tag_next.valid = 1'b1;
                tag_next.last  = (flush_reg == HW_W'(1));
                flush_next     = flush_reg - 1'b1;
            end else begin
                if (tag_reg.last) begin
                    for (int k = 0; k < WIN_DEPTH; k++) begin
                        window_next[k] = '0;
                    end
                end
                tag_next.valid = 1'b0;
                tag_next.last  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
                window_reg[k] <= '0;
            end
            primed_reg <= '0;
            flush_reg  <= '0;
            tag_reg    <= '0;
        end else begin
            window_reg <= window_next;
            primed_reg <= primed_next;
            flush_reg  <= flush_next;
            tag_reg    <= tag_next;
        end
    end

    assign tag = tag_reg;
    assign win = window_reg;

endmodule

### hdl/gsm_mac.sv
// Tap multipliers, adder tree, floor and saturation, and the output register.
// Depends on gsm_pkg.
module gsm_mac #(
    parameter int MAX_HALF_WIDTH = gsm_pkg::MAX_HALF_WIDTH_DEF,
    parameter int HEIGHT_BITS    = gsm_pkg::HEIGHT_BITS_DEF,
    parameter int WIN_DEPTH      = 2 * MAX_HALF_WIDTH + 1,
    parameter int HW_W           = $clog2(MAX_HALF_WIDTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [HW_W-1:0]               hw,
    input  logic [gsm_pkg::WEIGHT_W-1:0]  weight [gsm_pkg::NUM_WEIGHTS],
    input  gsm_pkg::gsm_tag_t             tag,
    input  logic signed [HEIGHT_BITS-1:0] win [WIN_DEPTH],
    output logic                          ready,
    output logic                          out_valid,
    output logic [HEIGHT_BITS-1:0]        out_smoothed,
    output logic                          out_last,
    input  logic                          out_ready
);

    localparam int PROD_W = HEIGHT_BITS + gsm_pkg::WEIGHT_W;
    localparam int ACC_W  = PROD_W + $clog2(WIN_DEPTH);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - HEIGHT_BITS + 1){1'b0}}, {(HEIGHT_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W - HEIGHT_BITS + 1){1'b1}}, {(HEIGHT_BITS - 1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg  [WIN_DEPTH];
    logic signed [PROD_W-1:0] prod_next [WIN_DEPTH];
    logic signed [PROD_W:0]   prod_full [WIN_DEPTH];
    logic [gsm_pkg::WEIGHT_W-1:0] tap_w [WIN_DEPTH];
    gsm_pkg::gsm_tag_t prod_tag_reg;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] quot;
    logic [HEIGHT_BITS-1:0]  sat;
    logic                    out_valid_reg;
    logic                    out_last_reg;
    logic [HEIGHT_BITS-1:0]  out_smoothed_reg;
    logic                    out_en;
    logic                    prod_en;

    assign out_en  = !out_valid_reg || out_ready;
    assign prod_en = !prod_tag_reg.valid || out_en;
    assign ready   = prod_en;

    // Window slot k sits at distance |k - hw| from the center; slots past 2*hw are off.
    always_comb begin
        for (int k = 0; k < WIN_DEPTH; k++) begin
            tap_w[k] = '0;
            for (int d = 0; d < gsm_pkg::NUM_WEIGHTS; d++) begin
                if ((d <= int'(hw)) &&
                    ((int'(hw) + d == k) || (int'(hw) - d == k))) begin
                    tap_w[k] = weight[d];
                end
            end
            prod_full[k] = $signed({1'b0, tap_w[k]}) * win[k];
            prod_next[k] = prod_full[k][PROD_W-1:0];
        end
    end

    always_comb begin
        acc = '0;
        for (int k = 0; k < WIN_DEPTH; k++) begin
            acc = acc + ACC_W'(prod_reg[k]);
        end
        quot = acc >>> gsm_pkg::FRAC_BITS;
        if (quot > SAT_HI) begin
            sat = SAT_HI[HEIGHT_BITS-1:0];
        end else if (quot < SAT_LO) begin
            sat = SAT_LO[HEIGHT_BITS-1:0];
        end else begin
            sat = quot[HEIGHT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_en) begin
            prod_reg <= prod_next;
        end
        if (out_en && prod_tag_reg.valid) begin
            out_smoothed_reg <= sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_tag_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else begin
            if (prod_en) begin
                prod_tag_reg <= tag;
            end
            if (out_en) begin
                out_valid_reg <= prod_tag_reg.valid;
                out_last_reg  <= prod_tag_reg.last;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_last     = out_last_reg;
    assign out_smoothed = out_smoothed_reg;

endmodule

### bench/gsm_smooth_checker.sv
`timescale 1ns / 100ps
// Watches both streams of the Gaussian smoothing unit and the register port,
// predicts each smoothed beat and compares it. Depends on gsm_pkg.
module gsm_smooth_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [gsm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gsm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // height
    input  logic                            s_tlast,   // row_end
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [15:0]                     m_tdata,   // smoothed
    input  logic                            m_tlast,   // last_out
    output int                              outstanding,
    output int                              fail_count
);
    localparam int HB    = gsm_pkg::HEIGHT_BITS_DEF;
    localparam int MAXHW = gsm_pkg::MAX_HALF_WIDTH_DEF;
    localparam int WIN   = 2 * MAXHW + 1;

    typedef struct packed {
        logic signed [HB-1:0] smoothed;
        logic                 last_out;
    } bin_result_t;

    logic [gsm_pkg::HALF_W_W-1:0] half_w;
    logic [gsm_pkg::WEIGHT_W-1:0] tap_wt [0:gsm_pkg::NUM_WEIGHTS-1];
    logic signed [HB-1:0]         win [0:WIN-1];
    int                           primed;
    bin_result_t                  smooth_q[$];

    function automatic void shift_bin(logic signed [HB-1:0] v);
        for (int i = WIN - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = v;
    endfunction

    function automatic logic signed [HB-1:0] centre_sum(int hw);
        longint acc;
        longint q;
        longint hi;
        longint lo;
        int     d;
        acc = 0;
        hi  = (longint'(1) <<< (HB - 1)) - 1;
        lo  = -(longint'(1) <<< (HB - 1));
        for (int k = 0; k <= 2 * hw; k++) begin
            d = (k > hw) ? k - hw : hw - k;
            acc += longint'(tap_wt[d]) * longint'(win[k]);
        end
        q = acc >>> gsm_pkg::FRAC_BITS;   // floor
        if (q > hi) q = hi;
        if (q < lo) q = lo;
        return q[HB-1:0];
    endfunction

    function automatic void predict_bin(logic signed [HB-1:0] h, logic row_end);
        int hw;
        int p;
        hw = half_w;
        if (hw > MAXHW) hw = MAXHW;
        p = primed;
        if (p > hw) p = hw;
        shift_bin(h);
        if (!row_end) begin
            if (p == hw) smooth_q.push_back(bin_result_t'{centre_sum(hw), 1'b0});
            else p++;
            primed = p;
        end else begin
            // flush: move oldest pending bin to the center, then emit all
            for (int k = p; k < hw; k++) shift_bin('0);
            for (int k = 0; k <= p; k++) begin
                smooth_q.push_back(bin_result_t'{centre_sum(hw), 1'(k == p)});
                if (k < p) shift_bin('0);
            end
            foreach (win[i]) win[i] = '0;
            primed = 0;
        end
    endfunction

    always @(posedge aclk) begin
        bin_result_t exp_bin;
        if (!aresetn) begin
            half_w    = gsm_pkg::HALF_WIDTH_RST;
            tap_wt[0] = gsm_pkg::WEIGHT_CENTER_RST;
            tap_wt[1] = gsm_pkg::WEIGHT_OFF1_RST;
            tap_wt[2] = gsm_pkg::WEIGHT_OFF2_RST;
            tap_wt[3] = gsm_pkg::WEIGHT_OFF3_RST;
            foreach (win[i]) win[i] = '0;
            primed     = 0;
            fail_count = 0;
            smooth_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (smooth_q.size() == 0) begin
                    $error("unexpected beat: smoothed %0d last_out %0b",
                           $signed(m_tdata[HB-1:0]), m_tlast);
                    fail_count++;
                end else begin
                    exp_bin = smooth_q.pop_front();
                    if (m_tdata[HB-1:0] !== exp_bin.smoothed) begin
                        $error("smoothed: expected %0d, actual %0d",
                               exp_bin.smoothed, $signed(m_tdata[HB-1:0]));
                        fail_count++;
                    end
                    if (m_tlast !== exp_bin.last_out) begin
                        $error("last_out: expected %0b, actual %0b",
                               exp_bin.last_out, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    gsm_pkg::CFG_HALF_WIDTH:    half_w    = cfg_wdata[gsm_pkg::HALF_W_W-1:0];
                    gsm_pkg::CFG_WEIGHT_CENTER: tap_wt[0] = cfg_wdata;
                    gsm_pkg::CFG_WEIGHT_OFF1:   tap_wt[1] = cfg_wdata;
                    gsm_pkg::CFG_WEIGHT_OFF2:   tap_wt[2] = cfg_wdata;
                    gsm_pkg::CFG_WEIGHT_OFF3:   tap_wt[3] = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_bin(s_tdata[HB-1:0], s_tlast);
        end
        outstanding <= smooth_q.size();
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Top of the smoothing unit bench: clock, reset, register writes and row stimulus.
// Depends on gsm_pkg, gaussian_smoothing_1d_unit and gsm_smooth_checker.
module tb;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;
    localparam int SETTLE      = 10;
    localparam int RANDOM_BINS = 80;
    localparam int CFG_UNUSED_LO = int'(gsm_pkg::CFG_WEIGHT_OFF3) + 1;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [gsm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [gsm_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // height
    logic        s_tlast;   // row_end
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // smoothed
    logic        m_tlast;   // last_out

    int outstanding;
    int fail_count;
    int cycle_count = 0;
    int bins_sent   = 0;
    int hold_ask    = 0;
    bit calm        = 1'b0;

    always #1 aclk = ~aclk;

    gaussian_smoothing_1d_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    gsm_smooth_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .outstanding(outstanding), .fail_count(fail_count)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin : receiver
        int seen;
        seen = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_ask != seen) begin
                seen = hold_ask;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 14);
            end
        end
    end

    task automatic send_bin(input logic [15:0] h, input logic row_end);
        while (!calm && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= h;
        s_tlast  <= row_end;
        do @(posedge aclk); while (!s_tready);
        bins_sent++;
    endtask

    function automatic logic [15:0] rand_height();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 32768));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_row(input int len);
        for (int i = 0; i < len; i++) send_bin(rand_height(), i == len - 1);
    endtask

    // drop valid, drain every expected beat, then give the pipeline time
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [gsm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [1:0] hw, input logic [15:0] wc,
                             input logic [15:0] w1, input logic [15:0] w2,
                             input logic [15:0] w3);
        settle();
        write_reg(gsm_pkg::CFG_HALF_WIDTH, {14'd0, hw});
        write_reg(gsm_pkg::CFG_WEIGHT_CENTER, wc);
        write_reg(gsm_pkg::CFG_WEIGHT_OFF1, w1);
        write_reg(gsm_pkg::CFG_WEIGHT_OFF2, w2);
        write_reg(gsm_pkg::CFG_WEIGHT_OFF3, w3);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        int rows;
        int target;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset kernel, height extremes
        send_bin(16'h7FFF, 1'b0);
        send_bin(16'h8000, 1'b0);
        send_bin(16'h0000, 1'b0);
        send_bin(16'hFFFF, 1'b0);
        send_bin(16'h0001, 1'b1);

        // widest kernel, full weights: saturation and short rows
        write_cfg(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_bin(16'h7FFF, 1'b0);
        send_bin(16'h7FFF, 1'b0);
        send_bin(16'h7FFF, 1'b1);
        send_bin(16'h8000, 1'b1);

        // zero half width
        write_cfg(2'd0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_bin(16'hFFFF, 1'b0);
        send_bin(16'd12345, 1'b0);
        send_bin(16'h8000, 1'b1);

        // writes to unused indexes must not disturb the kernel
        settle();
        for (int i = CFG_UNUSED_LO; i < (1 << gsm_pkg::CFG_INDEX_W); i++)
            write_reg(gsm_pkg::CFG_INDEX_W'(i), 16'($urandom));
        cfg_wr_en <= 1'b0;
        send_bin(16'h4000, 1'b0);
        send_bin(16'hC000, 1'b1);

        // half width shrinks in the middle of a row
        write_cfg(2'd3, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        send_bin(16'h1234, 1'b0);
        send_bin(16'hEDCB, 1'b0);
        settle();
        write_reg(gsm_pkg::CFG_HALF_WIDTH, 16'd1);
        cfg_wr_en <= 1'b0;
        send_bin(16'h7FFF, 1'b0);
        send_bin(16'h8000, 1'b0);
        send_bin(16'h0100, 1'b1);

        write_cfg(2'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_bin(16'h7FFF, 1'b0);
        send_bin(16'h8000, 1'b1);

        write_cfg(2'd2, 16'd26386, 16'd16004, 16'd3571, 16'd0);
        rows   = 0;
        target = bins_sent + RANDOM_BINS;
        while (bins_sent < target) begin
            if (rows == 4) begin
                // long receiver hold-off while the sender keeps pushing
                calm <= 1'b1;
                hold_ask <= hold_ask + 1;
                send_row(30);
            end else if (rows > 4 && rows < 9) begin
                send_row($urandom_range(1, 10));
            end else begin
                calm <= 1'b0;
                if (rows % 3 == 2)
                    write_cfg(2'($urandom_range(0, 3)), rand_weight(), rand_weight(),
                              rand_weight(), rand_weight());
                send_row(($urandom_range(7) == 0) ? $urandom_range(11, 24)
                                                  : $urandom_range(1, 10));
            end
            rows++;
        end

        settle();
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
